FILE: design/msc_pkg.sv
// Shared types and codes of the MIDI state chaser.
// No dependencies; the top level imports this package.
package msc_pkg;

  // Action codes of an input item.
  localparam logic [3:0] ACT_NOTE_ON  = 4'd0;
  localparam logic [3:0] ACT_RELEASE  = 4'd1;
  localparam logic [3:0] ACT_CTRL     = 4'd2;
  localparam logic [3:0] ACT_BEND     = 4'd3;
  localparam logic [3:0] ACT_PRESSURE = 4'd4;
  localparam logic [3:0] ACT_PROGRAM  = 4'd5;
  localparam logic [3:0] ACT_OTHER    = 4'd6;
  localparam logic [3:0] ACT_READ     = 4'd7;
  localparam logic [3:0] ACT_DUMP     = 4'd8;
  localparam logic [3:0] ACT_CLEAR    = 4'd9;

  // Read selectors.
  localparam logic [2:0] RD_CTRL     = 3'd0;
  localparam logic [2:0] RD_BEND     = 3'd1;
  localparam logic [2:0] RD_PRESSURE = 3'd2;
  localparam logic [2:0] RD_PROGRAM  = 3'd3;
  localparam logic [2:0] RD_SUSTAIN  = 3'd4;

  // Sustain controller and its threshold of 64.0 in Q16.16.
  localparam logic [6:0]         SUSTAIN_CTRL = 7'd64;
  localparam logic signed [31:0] SUSTAIN_ON   = 32'sh0040_0000;

  typedef struct packed {
    logic [3:0]         action;
    logic [3:0]         channel;
    logic [6:0]         key;
    logic signed [31:0] note_id;
    logic signed [31:0] value;
    logic signed [47:0] time_req;
    logic signed [47:0] duration;
    logic [6:0]         param_id;
    logic [2:0]         read_what;
  } item_t;

  typedef struct packed {
    logic               held_valid;
    logic [3:0]         held_channel;
    logic [6:0]         held_key;
    logic signed [31:0] held_note_id;
    logic signed [31:0] held_velocity;
    logic signed [47:0] held_start;
    logic signed [47:0] held_duration;
    logic [31:0]        held_source;
    logic               last_result;
    logic signed [31:0] read_value;
    logic               read_known;
    logic               table_overflow;
  } result_t;

endpackage

FILE: design/midi_state_chaser_unit.sv
// Top level of the MIDI state chaser: sequencer, note table and value tables.
// Depends on msc_pkg and msc_cmp.
//
// Channel   Signals                          Transfer when
// input     start, busy, item                start && !busy
// result    result_strobe, result            result_strobe (one cycle)
// config    cfg_valid, cfg_ready, cfg_data   cfg_valid && cfg_ready
//
// An event passes S_CHK and, for a note on, S_END if timed and S_INS before the
// next transfer; a release scans the note table through S_RADDR and S_RCHK per
// entry and then moves each later entry through S_SH_RD and S_SH_WR.
// A read passes S_CHK and S_READOUT; a dump gives one result per selection
// pass through the note table memory.
// After reset and after a clear all CHANNELS*CONTROLLERS controller memory
// entries are swept with busy high; configuration writes go on.
// The receiver cannot stall: each result shows for one cycle only.
module midi_state_chaser_unit #(
  parameter int MAX_NOTES   = 64,
  parameter int CHANNELS    = 16,
  parameter int CONTROLLERS = 128
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  msc_pkg::item_t     item,
  output logic               result_strobe,
  output msc_pkg::result_t   result,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic signed [47:0] cfg_data
);
  import msc_pkg::*;

  localparam int IW       = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;
  localparam int CNT_W    = $clog2(MAX_NOTES + 1);
  localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CT_DEPTH = CHANNELS * CONTROLLERS;
  localparam int CA_W     = $clog2(CT_DEPTH);
  localparam int KEY_W    = 91 + IW;

  typedef struct packed {
    logic [3:0]         chan;
    logic [6:0]         key;
    logic signed [31:0] ident;
    logic signed [31:0] vel;
    logic signed [47:0] start_t;
    logic signed [47:0] len;
    logic [31:0]        src;
    logic               open;
  } note_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CLR, S_CHK, S_END, S_INS, S_RADDR, S_RCHK, S_SH_RD, S_SH_WR,
    S_READOUT, S_DADDR, S_DCHK1, S_DCHK2, S_EMIT
  } state_t;

  function automatic logic [47:0] bias48(input logic [47:0] x);
    return {~x[47], x[46:0]};
  endfunction

  function automatic logic [48:0] bias49(input logic [48:0] x);
    return {~x[48], x[47:0]};
  endfunction

  state_t             state;
  item_t              ev;
  logic signed [47:0] chase;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   i;
  logic [CNT_W-1:0]   j;
  logic [31:0]        counter;
  logic [31:0]        ev_idx;
  logic               overflow;
  logic signed [48:0] end_sum;
  logic [CA_W-1:0]    clr_cnt;
  logic               have_prev;
  logic               best_valid;
  logic [KEY_W-1:0]   prev_key;
  logic [KEY_W-1:0]   best_key;
  note_t              best;

  logic signed [31:0] bend_val [CHANNELS];
  logic signed [31:0] pres_val [CHANNELS];
  logic signed [31:0] prog_val [CHANNELS];
  logic               sus_val  [CHANNELS];
  logic [CHANNELS-1:0] bend_kn;
  logic [CHANNELS-1:0] pres_kn;
  logic [CHANNELS-1:0] prog_kn;
  logic [CHANNELS-1:0] sus_kn;

  // Note table memory with registered read.
  note_t            note_mem [MAX_NOTES];
  note_t            rdata;
  logic             n_we;
  logic [IW-1:0]    n_wa;
  note_t            n_wd;
  logic [IW-1:0]    n_ra;

  // Controller memory: known bit over the value.
  logic [32:0]      ctrl_mem [CT_DEPTH];
  logic [32:0]      c_rdata;
  logic             c_we;
  logic [CA_W-1:0]  c_wa;
  logic [32:0]      c_wd;
  logic [CA_W-1:0]  ctrl_addr;

  logic [KEY_W-1:0] cmp_a;
  logic [KEY_W-1:0] cmp_b;
  logic             cmp_lt;
  logic             cmp_eq;

  logic             chan_ok;
  logic             pid_ok;
  logic [CH_W-1:0]  ch;
  logic             dur_pos;
  logic signed [31:0] prog_trunc;
  logic [KEY_W-1:0] cand_key;
  note_t            new_note;
  logic             strobe_next;
  result_t          result_next;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  // Decoded fields of the latched item.
  assign chan_ok   = {1'b0, ev.channel} < 5'(CHANNELS);
  assign pid_ok    = {1'b0, ev.param_id} < 8'(CONTROLLERS);
  assign ch        = ev.channel[CH_W-1:0];
  assign dur_pos   = !ev.duration[47] && (ev.duration != '0);
  assign ctrl_addr = CA_W'(ev.channel) * CA_W'(CONTROLLERS) + CA_W'(ev.param_id);
  assign prog_trunc = (ev.value >>> 16) +
                      32'(ev.value[31] && (ev.value[15:0] != '0));
  assign cand_key  = {bias48(rdata.start_t), rdata.chan, rdata.key,
                      ~rdata.ident[31], rdata.ident[30:0], i[IW-1:0]};

  always_comb begin
    new_note.chan    = ev.channel;
    new_note.key     = ev.key;
    new_note.ident   = ev.note_id;
    new_note.vel     = ev.value;
    new_note.start_t = ev.time_req;
    new_note.len     = dur_pos ? ev.duration : '0;
    new_note.src     = ev_idx;
    new_note.open    = !dur_pos;
  end

  // Operand selection for the shared comparator.
  always_comb begin
    case (state)
      S_CHK: begin
        cmp_a = KEY_W'(bias48(ev.time_req));
        cmp_b = KEY_W'(bias48(chase));
      end
      S_END: begin
        cmp_a = KEY_W'(bias49({chase[47], chase}));
        cmp_b = KEY_W'(bias49(end_sum));
      end
      S_RCHK: begin
        cmp_a = KEY_W'({ev.channel, ev.key});
        cmp_b = KEY_W'({rdata.chan, rdata.key});
      end
      S_DCHK1: begin
        cmp_a = prev_key;
        cmp_b = cand_key;
      end
      S_DCHK2: begin
        cmp_a = cand_key;
        cmp_b = best_key;
      end
      default: begin
        cmp_a = '0;
        cmp_b = '0;
      end
    endcase
  end

  msc_cmp #(.W(KEY_W)) u_cmp (
    .a  (cmp_a),
    .b  (cmp_b),
    .lt (cmp_lt),
    .eq (cmp_eq)
  );

  // Note memory port control.
  always_comb begin
    n_we = 1'b0;
    n_wa = count[IW-1:0];
    n_wd = new_note;
    n_ra = i[IW-1:0];
    case (state)
      S_INS: begin
        n_we = (count < CNT_W'(MAX_NOTES));
      end
      S_SH_RD: begin
        n_ra = IW'(i + CNT_W'(1));
      end
      S_SH_WR: begin
        n_we = 1'b1;
        n_wa = i[IW-1:0];
        n_wd = rdata;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (n_we) begin
      note_mem[n_wa] <= n_wd;
    end
    rdata <= note_mem[n_ra];
  end

  // Controller memory port control: sweep or event write.
  always_comb begin
    c_we = 1'b0;
    c_wa = ctrl_addr;
    c_wd = {1'b1, ev.value};
    case (state)
      S_CLR: begin
        c_we = 1'b1;
        c_wa = clr_cnt;
        c_wd = '0;
      end
      S_CHK: begin
        c_we = (ev.action == ACT_CTRL) && cmp_lt && chan_ok && pid_ok;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (c_we) begin
      ctrl_mem[c_wa] <= c_wd;
    end
    c_rdata <= ctrl_mem[ctrl_addr];
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      chase <= '0;
    end else if (cfg_valid && cfg_ready) begin
      chase <= cfg_data;
    end
  end

  // A result leaves from the read step, each dump pass and an empty dump.
  assign strobe_next = (state == S_READOUT) || (state == S_EMIT) ||
                       ((state == S_CHK) && (ev.action == ACT_DUMP) && (count == '0));

  // Result word of the current sequencer step.
  always_comb begin
    result_next = '0;
    result_next.table_overflow = overflow;
    case (state)
      S_CHK: begin
        result_next.last_result = 1'b1;
      end
      S_READOUT: begin
        result_next.last_result = 1'b1;
        if (chan_ok) begin
          case (ev.read_what)
            RD_CTRL: begin
              if (pid_ok && c_rdata[32]) begin
                result_next.read_value = c_rdata[31:0];
                result_next.read_known = 1'b1;
              end
            end
            RD_BEND: begin
              if (bend_kn[ch]) begin
                result_next.read_value = bend_val[ch];
                result_next.read_known = 1'b1;
              end
            end
            RD_PRESSURE: begin
              if (pres_kn[ch]) begin
                result_next.read_value = pres_val[ch];
                result_next.read_known = 1'b1;
              end
            end
            RD_PROGRAM: begin
              if (prog_kn[ch]) begin
                result_next.read_value = prog_val[ch];
                result_next.read_known = 1'b1;
              end
            end
            RD_SUSTAIN: begin
              if (sus_kn[ch]) begin
                result_next.read_value = 32'(sus_val[ch]);
                result_next.read_known = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_EMIT: begin
        result_next.held_valid    = 1'b1;
        result_next.held_channel  = best.chan;
        result_next.held_key      = best.key;
        result_next.held_note_id  = best.ident;
        result_next.held_velocity = best.vel;
        result_next.held_start    = best.start_t;
        result_next.held_duration = best.len;
        result_next.held_source   = best.src;
        result_next.last_result   = (j + CNT_W'(1) == count);
      end
      default: begin
      end
    endcase
  end

  // Sequencer with registered result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLR;
      clr_cnt       <= '0;
      count         <= '0;
      counter       <= '0;
      overflow      <= 1'b0;
      bend_kn       <= '0;
      pres_kn       <= '0;
      prog_kn       <= '0;
      sus_kn        <= '0;
      result_strobe <= 1'b0;
      have_prev     <= 1'b0;
      best_valid    <= 1'b0;
    end else begin
      result_strobe <= strobe_next;
      if (strobe_next) begin
        result <= result_next;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            ev    <= item;
            state <= S_CHK;
          end
        end

        // Controller memory sweep after reset or clear.
        S_CLR: begin
          if (clr_cnt == CA_W'(CT_DEPTH - 1)) begin
            clr_cnt <= '0;
            state   <= S_IDLE;
          end else begin
            clr_cnt <= clr_cnt + CA_W'(1);
          end
        end

        // Time check against the chase position, then dispatch.
        S_CHK: begin
          if (ev.action <= ACT_OTHER) begin
            if (cmp_lt) begin
              ev_idx  <= counter;
              counter <= counter + 32'd1;
              case (ev.action)
                ACT_NOTE_ON: begin
                  end_sum <= 49'(ev.time_req) + 49'(ev.duration);
                  state   <= dur_pos ? S_END : S_INS;
                end
                ACT_RELEASE: begin
                  i     <= '0;
                  state <= (count != '0) ? S_RADDR : S_IDLE;
                end
                ACT_CTRL: begin
                  if (chan_ok && pid_ok && ev.param_id == SUSTAIN_CTRL) begin
                    sus_val[ch] <= (ev.value >= SUSTAIN_ON);
                    sus_kn[ch]  <= 1'b1;
                  end
                  state <= S_IDLE;
                end
                ACT_BEND: begin
                  if (chan_ok) begin
                    bend_val[ch] <= ev.value;
                    bend_kn[ch]  <= 1'b1;
                  end
                  state <= S_IDLE;
                end
                ACT_PRESSURE: begin
                  if (chan_ok) begin
                    pres_val[ch] <= ev.value;
                    pres_kn[ch]  <= 1'b1;
                  end
                  state <= S_IDLE;
                end
                ACT_PROGRAM: begin
                  if (chan_ok) begin
                    prog_val[ch] <= prog_trunc;
                    prog_kn[ch]  <= 1'b1;
                  end
                  state <= S_IDLE;
                end
                default: begin
                  state <= S_IDLE;
                end
              endcase
            end else begin
              state <= S_IDLE;
            end
          end else if (ev.action == ACT_READ) begin
            state <= S_READOUT;
          end else if (ev.action == ACT_DUMP) begin
            if (count == '0) begin
              state <= S_IDLE;
            end else begin
              i          <= '0;
              j          <= '0;
              have_prev  <= 1'b0;
              best_valid <= 1'b0;
              state      <= S_DADDR;
            end
          end else if (ev.action == ACT_CLEAR) begin
            count    <= '0;
            counter  <= '0;
            overflow <= 1'b0;
            bend_kn  <= '0;
            pres_kn  <= '0;
            prog_kn  <= '0;
            sus_kn   <= '0;
            clr_cnt  <= '0;
            state    <= S_CLR;
          end else begin
            state <= S_IDLE;
          end
        end

        // A timed note that already ended is skipped.
        S_END: begin
          state <= cmp_lt ? S_INS : S_IDLE;
        end

        S_INS: begin
          if (count < CNT_W'(MAX_NOTES)) begin
            count <= count + CNT_W'(1);
          end else begin
            overflow <= 1'b1;
          end
          state <= S_IDLE;
        end

        // Release: find the oldest open note on the channel and key.
        S_RADDR: begin
          state <= S_RCHK;
        end

        S_RCHK: begin
          if (cmp_eq && rdata.open) begin
            state <= S_SH_RD;
          end else if (i + CNT_W'(1) >= count) begin
            state <= S_IDLE;
          end else begin
            i     <= i + CNT_W'(1);
            state <= S_RADDR;
          end
        end

        // Close the gap one entry at a time.
        S_SH_RD: begin
          if (i + CNT_W'(1) < count) begin
            state <= S_SH_WR;
          end else begin
            count <= count - CNT_W'(1);
            state <= S_IDLE;
          end
        end

        S_SH_WR: begin
          i     <= i + CNT_W'(1);
          state <= S_SH_RD;
        end

        // Read result; the controller entry arrives from memory.
        S_READOUT: begin
          state <= S_IDLE;
        end

        // Dump: each pass selects the smallest key above the last one sent.
        S_DADDR: begin
          state <= S_DCHK1;
        end

        S_DCHK1: begin
          if (have_prev && !cmp_lt) begin
            if (i + CNT_W'(1) == count) begin
              state <= S_EMIT;
            end else begin
              i     <= i + CNT_W'(1);
              state <= S_DADDR;
            end
          end else begin
            state <= S_DCHK2;
          end
        end

        S_DCHK2: begin
          if (!best_valid || cmp_lt) begin
            best_valid <= 1'b1;
            best_key   <= cand_key;
            best       <= rdata;
          end
          if (i + CNT_W'(1) == count) begin
            state <= S_EMIT;
          end else begin
            i     <= i + CNT_W'(1);
            state <= S_DADDR;
          end
        end

        S_EMIT: begin
          prev_key   <= best_key;
          have_prev  <= 1'b1;
          best_valid <= 1'b0;
          i          <= '0;
          j          <= j + CNT_W'(1);
          state      <= (j + CNT_W'(1) == count) ? S_IDLE : S_DADDR;
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The note count never passes the table depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_NOTES))
    else $error("note count above table depth");

  // An accepted item always keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted item did not start the sequencer");

  // A result is only produced from sequencer work, never while idle before.
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> $past(busy))
    else $error("result strobe without sequencer work");

  // Every dump result other than the empty one carries a held note.
  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT |-> best_valid)
    else $error("dump pass emitted without a selected note");

endmodule

FILE: design/msc_cmp.sv
// Shared magnitude comparator of the state chaser sequencer.
// Depends on nothing; operands arrive already biased to unsigned form.
module msc_cmp #(
  parameter int W = 97
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic         lt,
  output logic         eq
);

  // One wide unsigned compare serves every ordering question.
  assign lt = a < b;
  assign eq = a == b;

endmodule
